@@ rtl/jlcg_pkg.sv @@
// shared types and constants of the 48-bit congruential generator
`timescale 1ns / 1ps

package jlcg_pkg;

   // word sizes
   localparam int STATE_WIDTH = 48;
   localparam int DRAW_WIDTH  = 31;
   localparam int FRAC_HI     = 26;
   localparam int FRAC_LO     = 27;
   localparam int VALUE_WIDTH = 53;
   localparam int COUNT_WIDTH = 6;
   localparam int TRY_WIDTH   = 8;
   localparam int DIV_STEPS   = 31;
   localparam int DIV_CNT_W   = 5;

   // largest raw draw
   localparam logic [COUNT_WIDTH-1:0] RAW_MAX_BITS = 6'd32;

   // last allowed draw of a rejected bounded draw (256 draws in all)
   localparam logic [TRY_WIDTH-1:0] TRY_LAST = 8'hFF;

   // register reset values
   localparam logic [STATE_WIDTH-1:0] MULT_RESET = 48'h0005_DEEC_E66D;
   localparam logic [STATE_WIDTH-1:0] INC_RESET  = 48'h0000_0000_000B;
   // zero seed scrambled with the reset multiplier
   localparam logic [STATE_WIDTH-1:0] LCG_STATE_RESET = 48'h0005_DEEC_E66D;

   // request kinds
   typedef enum logic [1:0] {
      ACT_RAW      = 2'd0,
      ACT_BOUNDED  = 2'd1,
      ACT_FRACTION = 2'd2,
      ACT_RESEED   = 2'd3
   } action_type;

   // register indexes
   typedef enum logic {
      CSR_MULTIPLIER = 1'b0,
      CSR_INCREMENT  = 1'b1
   } csr_index_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STEP,
      ST_EVAL,
      ST_DIV,
      ST_FIN
   } ctl_state_type;

endpackage

@@ rtl/java_lcg_random_generator.sv @@
// top level of the 48-bit congruential random generator
//
//   group  dir  beat contents (low bit first)
//   req_   in   action[1:0] bit_count[7:2] upper_bound[38:8] seed_value[86:39]
//   rsp_   out  value[52:0]
//   csr_   in   index 0 multiplier, index 1 increment, 48-bit data
//
// one generator step is a serial shift-add over the state bits that ends early
// when the state has high zero bits; a separate state then evaluates the draw.
// raw and power-of-two bounded draws take one step; fractions take two steps;
// other bounded draws add a serial remainder per draw, and a rejected draw
// repeats the step, at most 256 draws. reseed is taken while idle, with no step.
// req_tready is low while an item is in work; a held result does not block the
// next request, only its final write. reset is synchronous; no clearing pass is
// needed.
`timescale 1ns / 1ps

module java_lcg_random_generator (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [87:0]  req_tdata,   // action, bit_count, upper_bound, seed_value, pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [55:0]  rsp_tdata,   // value, pad
   input  logic         csr_we,
   input  logic         csr_addr,
   input  logic [47:0]  csr_wdata
);

   localparam int SW = jlcg_pkg::STATE_WIDTH;
   localparam int DW = jlcg_pkg::DRAW_WIDTH;
   localparam int VW = jlcg_pkg::VALUE_WIDTH;

   // request fields
   jlcg_pkg::action_type                req_action;
   logic [jlcg_pkg::COUNT_WIDTH-1:0]    req_bits;
   logic [DW-1:0]                       req_bound;
   logic [SW-1:0]                       req_seed;

   assign req_action = jlcg_pkg::action_type'(req_tdata[1:0]);
   assign req_bits   = req_tdata[7:2];
   assign req_bound  = req_tdata[38:8];
   assign req_seed   = req_tdata[86:39];

   // registers
   jlcg_pkg::ctl_state_type           state_ff, state_in;
   jlcg_pkg::action_type              act_ff, act_in;
   logic [jlcg_pkg::COUNT_WIDTH-1:0]  bits_ff, bits_in;
   logic [DW-1:0]                     bound_ff, bound_in;
   logic                              second_ff, second_in;
   logic [jlcg_pkg::FRAC_HI-1:0]      hi_ff, hi_in;
   logic [DW-1:0]                     u_ff, u_in;
   logic [jlcg_pkg::TRY_WIDTH-1:0]    tries_ff, tries_in;
   logic [VW-1:0]                     val_ff, val_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]                     rsp_data_ff, rsp_data_in;
   logic [SW-1:0]                     mul_ff, mul_in;
   logic [SW-1:0]                     inc_ff, inc_in;

   // unit handshakes
   logic          step_start;
   logic          step_reseed;
   logic          step_done;
   logic [SW-1:0] lcg_state;
   logic          div_start;
   logic          div_done;
   logic [DW-1:0] div_rem;

   // draw evaluation
   logic [jlcg_pkg::COUNT_WIDTH-1:0]  bits_sat;
   logic [jlcg_pkg::COUNT_WIDTH-1:0]  raw_shift;
   logic [VW-1:0]                     raw_val;
   logic [DW-1:0]                     draw31;
   logic                              bound_pow2;
   logic [DW-1:0]                     pow2_val;
   logic [DW:0]                       rej_sum;
   logic                              draw_ok;
   logic                              slot_free;
   logic                              seq_take;

   // state and remainder units
   jlcg_step u_step (
      .clock      (clock),
      .reset      (reset),
      .start      (step_start),
      .reseed     (step_reseed),
      .seed_value (req_seed),
      .multiplier (mul_ff),
      .increment  (inc_ff),
      .done       (step_done),
      .lcg_state  (lcg_state)
   );

   // the dividend is the fresh draw, captured by the unit at its start
   jlcg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (draw31),
      .divisor   (bound_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   // raw draw: top bits of the new state, zero bits shift everything out
   assign bits_sat  = (req_bits > jlcg_pkg::RAW_MAX_BITS) ? jlcg_pkg::RAW_MAX_BITS : req_bits;
   assign raw_shift = jlcg_pkg::COUNT_WIDTH'(SW) - bits_ff;
   assign raw_val   = VW'(lcg_state >> raw_shift);

   // bounded draw helpers
   assign draw31     = lcg_state[SW-1 -: DW];
   assign bound_pow2 = (bound_ff & (bound_ff - 1'b1)) == '0;

   // power-of-two bound: (bound * draw) >> 31 is a right shift by 31 less the bit position
   always_comb begin
      pow2_val = '0;
      for (int i = 0; i < DW; i++) begin
         if (bound_ff[i]) begin
            pow2_val = pow2_val | (draw31 >> (DW - i));
         end
      end
   end

   // reject when draw - rem + (bound - 1) overflows a signed 32-bit word
   assign rej_sum = {1'b0, u_ff} - {1'b0, div_rem} + {1'b0, bound_ff} - 1'b1;
   assign draw_ok = !rej_sum[DW];

   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign seq_take  = req_tvalid && (state_ff == jlcg_pkg::ST_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         jlcg_pkg::ST_IDLE: begin
            if (req_tvalid && (req_action != jlcg_pkg::ACT_RESEED)) begin
               state_in = jlcg_pkg::ST_STEP;
            end
         end
         jlcg_pkg::ST_STEP: begin
            if (step_done) begin
               state_in = jlcg_pkg::ST_EVAL;
            end
         end
         jlcg_pkg::ST_EVAL: begin
            unique case (act_ff)
               jlcg_pkg::ACT_FRACTION:
                  state_in = second_ff ? jlcg_pkg::ST_FIN : jlcg_pkg::ST_STEP;
               jlcg_pkg::ACT_BOUNDED:
                  state_in = bound_pow2 ? jlcg_pkg::ST_FIN : jlcg_pkg::ST_DIV;
               default:
                  state_in = jlcg_pkg::ST_FIN;
            endcase
         end
         jlcg_pkg::ST_DIV: begin
            if (div_done) begin
               if (draw_ok || (tries_ff == jlcg_pkg::TRY_LAST)) begin
                  state_in = jlcg_pkg::ST_FIN;
               end else begin
                  state_in = jlcg_pkg::ST_STEP;
               end
            end
         end
         jlcg_pkg::ST_FIN: begin
            if (slot_free) begin
               state_in = jlcg_pkg::ST_IDLE;
            end
         end
         default: state_in = jlcg_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready  = 1'b0;
      step_start  = 1'b0;
      step_reseed = 1'b0;
      div_start   = 1'b0;
      unique case (state_ff)
         jlcg_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            step_reseed = req_tvalid && (req_action == jlcg_pkg::ACT_RESEED);
            step_start  = req_tvalid && (req_action != jlcg_pkg::ACT_RESEED);
         end
         jlcg_pkg::ST_EVAL: begin
            step_start = (act_ff == jlcg_pkg::ACT_FRACTION) && !second_ff;
            div_start  = (act_ff == jlcg_pkg::ACT_BOUNDED) && !bound_pow2;
         end
         jlcg_pkg::ST_DIV: begin
            step_start = div_done && !draw_ok && (tries_ff != jlcg_pkg::TRY_LAST);
         end
         jlcg_pkg::ST_STEP, jlcg_pkg::ST_FIN: begin
            step_start = 1'b0;
         end
         default: begin
            step_start = 1'b0;
         end
      endcase
   end

   // request, draw and result bookkeeping
   always_comb begin
      act_in       = act_ff;
      bits_in      = bits_ff;
      bound_in     = bound_ff;
      second_in    = second_ff;
      hi_in        = hi_ff;
      u_in         = u_ff;
      tries_in     = tries_ff;
      val_in       = val_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (seq_take) begin
         act_in    = req_action;
         bits_in   = bits_sat;
         bound_in  = req_bound;
         second_in = 1'b0;
         tries_in  = '0;
      end
      if (state_ff == jlcg_pkg::ST_EVAL) begin
         case (act_ff)
            jlcg_pkg::ACT_RAW: begin
               val_in = raw_val;
            end
            jlcg_pkg::ACT_FRACTION: begin
               hi_in     = lcg_state[SW-1 -: jlcg_pkg::FRAC_HI];
               second_in = 1'b1;
               val_in    = {hi_ff, lcg_state[SW-1 -: jlcg_pkg::FRAC_LO]};
            end
            jlcg_pkg::ACT_BOUNDED: begin
               u_in   = draw31;
               val_in = VW'(pow2_val);
            end
            default: begin
               val_in = '0;
            end
         endcase
      end
      if ((state_ff == jlcg_pkg::ST_DIV) && div_done) begin
         val_in   = VW'(div_rem);
         tries_in = tries_ff + 1'b1;
      end
      if ((state_ff == jlcg_pkg::ST_FIN) && slot_free) begin
         rsp_data_in  = val_ff;
         rsp_valid_in = 1'b1;
      end
   end

   // register writes
   always_comb begin
      mul_in = mul_ff;
      inc_in = inc_ff;
      if (csr_we) begin
         unique case (jlcg_pkg::csr_index_type'(csr_addr))
            jlcg_pkg::CSR_MULTIPLIER: mul_in = csr_wdata;
            jlcg_pkg::CSR_INCREMENT:  inc_in = csr_wdata;
            default:                  mul_in = mul_ff;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jlcg_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mul_ff       <= jlcg_pkg::MULT_RESET;
         inc_ff       <= jlcg_pkg::INC_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         mul_ff       <= mul_in;
         inc_ff       <= inc_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      bits_ff     <= bits_in;
      bound_ff    <= bound_in;
      second_ff   <= second_in;
      hi_ff       <= hi_in;
      u_ff        <= u_in;
      tries_ff    <= tries_in;
      val_ff      <= val_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff};

   // units are never started together
   a_one_start: assert property (@(posedge clock) disable iff (reset)
      !(step_start && div_start))
      else $error("step and remainder units started in the same cycle");

   // a result beat appears only out of the final state
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == jlcg_pkg::ST_FIN))
      else $error("result raised outside the final state");

   // remainder completes only while the sequencer waits for it
   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == jlcg_pkg::ST_DIV))
      else $error("remainder done outside the divide state");

   // the retry count never wraps past the last draw
   a_retry_cap: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == jlcg_pkg::ST_DIV) && div_done && (tries_ff == jlcg_pkg::TRY_LAST))
      |=> (state_ff == jlcg_pkg::ST_FIN))
      else $error("bounded draw retried beyond the limit");

endmodule

@@ rtl/jlcg_step.sv @@
// generator state and its serial shift-add multiply-accumulate unit
`timescale 1ns / 1ps

module jlcg_step (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                reseed,
   input  logic [jlcg_pkg::STATE_WIDTH-1:0]    seed_value,
   input  logic [jlcg_pkg::STATE_WIDTH-1:0]    multiplier,
   input  logic [jlcg_pkg::STATE_WIDTH-1:0]    increment,
   output logic                                done,
   output logic [jlcg_pkg::STATE_WIDTH-1:0]    lcg_state
);

   logic [jlcg_pkg::STATE_WIDTH-1:0] lcg_ff,    lcg_in;
   logic [jlcg_pkg::STATE_WIDTH-1:0] acc_ff,    acc_in;
   logic [jlcg_pkg::STATE_WIDTH-1:0] mcand_ff,  mcand_in;
   logic [jlcg_pkg::STATE_WIDTH-1:0] mplier_ff, mplier_in;
   logic                             busy_ff,   busy_in;

   // finished once no multiplier bits remain
   assign done      = busy_ff && (mplier_ff == '0);
   assign lcg_state = lcg_ff;

   // one conditional add per cycle, product taken mod 2^48
   always_comb begin
      lcg_in    = lcg_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      busy_in   = busy_ff;
      if (reseed) begin
         lcg_in = seed_value ^ multiplier;
      end else if (start) begin
         acc_in    = increment;
         mcand_in  = multiplier;
         mplier_in = lcg_ff;
         busy_in   = 1'b1;
      end else if (done) begin
         lcg_in  = acc_ff;
         busy_in = 1'b0;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = {mcand_ff[jlcg_pkg::STATE_WIDTH-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[jlcg_pkg::STATE_WIDTH-1:1]};
      end
   end

   // control and generator state
   always_ff @(posedge clock) begin
      if (reset) begin
         lcg_ff  <= jlcg_pkg::LCG_STATE_RESET;
         busy_ff <= 1'b0;
      end else begin
         lcg_ff  <= lcg_in;
         busy_ff <= busy_in;
      end
   end

   // operand registers
   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

endmodule

@@ rtl/jlcg_div.sv @@
// serial restoring remainder unit, one quotient bit per cycle
`timescale 1ns / 1ps

module jlcg_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [jlcg_pkg::DRAW_WIDTH-1:0]    dividend,
   input  logic [jlcg_pkg::DRAW_WIDTH-1:0]    divisor,   // held by caller while busy
   output logic                               done,
   output logic [jlcg_pkg::DRAW_WIDTH-1:0]    remainder
);

   logic [jlcg_pkg::DRAW_WIDTH-1:0] rem_ff,  rem_in;
   logic [jlcg_pkg::DRAW_WIDTH-1:0] dvd_ff,  dvd_in;
   logic [jlcg_pkg::DIV_CNT_W-1:0]  cnt_ff,  cnt_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [jlcg_pkg::DRAW_WIDTH:0]   trial;
   logic [jlcg_pkg::DRAW_WIDTH:0]   diff;

   assign done      = done_ff;
   assign remainder = rem_ff;

   // shift in the next dividend bit and try the subtract
   assign trial = {rem_ff, dvd_ff[jlcg_pkg::DRAW_WIDTH-1]};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         dvd_in  = dividend;
         cnt_in  = jlcg_pkg::DIV_CNT_W'(jlcg_pkg::DIV_STEPS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (diff[jlcg_pkg::DRAW_WIDTH]) begin
            rem_in = trial[jlcg_pkg::DRAW_WIDTH-1:0];
         end else begin
            rem_in = diff[jlcg_pkg::DRAW_WIDTH-1:0];
         end
         dvd_in = {dvd_ff[jlcg_pkg::DRAW_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      cnt_ff <= cnt_in;
   end

endmodule
